>>> sv/pitrl_pkg.sv
// Shared constants, types and command/status structs for the triangle region lookup.
package pitrl_pkg;

  localparam int MAX_TRIANGLES = 256;
  localparam int COORD_BITS    = 32;
  localparam int REGION_BITS   = 8;

  localparam int IDX_W  = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int CNT_W  = $clog2(MAX_TRIANGLES + 1);
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;

  localparam int ACTION_W   = 2;
  localparam int FIELD_W    = 32;
  localparam int TAG_W      = 8;
  localparam int OUT_REG_W  = 8;
  localparam int IN_TDATA_W = 264;
  localparam int OUT_TDATA_W = 16;

  localparam int OFF_TAG = 0;
  localparam int OFF_AX  = 8;
  localparam int OFF_AY  = 40;
  localparam int OFF_BX  = 72;
  localparam int OFF_BY  = 104;
  localparam int OFF_CX  = 136;
  localparam int OFF_CY  = 168;
  localparam int OFF_PX  = 200;
  localparam int OFF_PY  = 232;

  localparam int ENTRY_W = 6 * COORD_BITS + REGION_BITS;

  localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic [REGION_BITS-1:0]       region_t;

  typedef struct packed {
    logic             capture;
    logic             full_flag;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic found;
    logic busy;
  } dp_sts_t;

endpackage

>>> sv/pitrl_dp.sv
// Datapath: triangle memory, three-stage edge test pipeline and result registers.
module pitrl_dp
  import pitrl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  dp_cmd_t                cmd,
  output dp_sts_t                sts,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [ENTRY_W-1:0] mem [MAX_TRIANGLES];
  logic [ENTRY_W-1:0] rd_q_r;

  coord_t  px_r, py_r;
  logic    v1_r, v2_r, v3_r;
  diff_t   dx_r [3];
  diff_t   dy_r [3];
  diff_t   rx_r [3];
  diff_t   ry_r [3];
  diff_t   dx_nxt [3];
  diff_t   dy_nxt [3];
  diff_t   rx_nxt [3];
  diff_t   ry_nxt [3];
  prod_t   pa_r [3];
  prod_t   pb_r [3];
  region_t reg2_r, reg3_r;
  logic    found_r, full_r;
  region_t region_r;
  logic [OUT_REG_W-1:0] out_region_r;
  logic    out_hit_r, out_full_r;
  logic    all_neg;
  coord_t  vx [3];
  coord_t  vy [3];
  logic [ENTRY_W-1:0] wr_entry;

  assign wr_entry = {
    REGION_BITS'(in_tdata[OFF_TAG +: TAG_W]),
    coord_t'(in_tdata[OFF_CY +: FIELD_W]), coord_t'(in_tdata[OFF_CX +: FIELD_W]),
    coord_t'(in_tdata[OFF_BY +: FIELD_W]), coord_t'(in_tdata[OFF_BX +: FIELD_W]),
    coord_t'(in_tdata[OFF_AY +: FIELD_W]), coord_t'(in_tdata[OFF_AX +: FIELD_W])
  };

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_idx] <= wr_entry;
    end
    if (cmd.rd_en) begin
      rd_q_r <= mem[cmd.rd_idx];
    end
  end

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      vx[v] = rd_q_r[(2 * v) * COORD_BITS +: COORD_BITS];
      vy[v] = rd_q_r[(2 * v + 1) * COORD_BITS +: COORD_BITS];
    end
    for (int e = 0; e < 3; e++) begin
      dx_nxt[e] = diff_t'(vx[(e + 1) % 3]) - diff_t'(vx[e]);
      dy_nxt[e] = diff_t'(vy[(e + 1) % 3]) - diff_t'(vy[e]);
      rx_nxt[e] = diff_t'(px_r) - diff_t'(vx[e]);
      ry_nxt[e] = diff_t'(py_r) - diff_t'(vy[e]);
    end
  end

  always_ff @(posedge clk) begin
    for (int e = 0; e < 3; e++) begin
      dx_r[e] <= dx_nxt[e];
      dy_r[e] <= dy_nxt[e];
      rx_r[e] <= rx_nxt[e];
      ry_r[e] <= ry_nxt[e];
      pa_r[e] <= prod_t'(rx_r[e]) * prod_t'(dy_r[e]);
      pb_r[e] <= prod_t'(ry_r[e]) * prod_t'(dx_r[e]);
    end
    reg2_r <= rd_q_r[6 * COORD_BITS +: REGION_BITS];
    reg3_r <= reg2_r;
  end

  // The point is strictly inside when every edge product difference is negative.
  assign all_neg = (pa_r[0] < pb_r[0]) && (pa_r[1] < pb_r[1]) && (pa_r[2] < pb_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      found_r <= 1'b0;
      full_r  <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (cmd.capture) begin
        found_r <= 1'b0;
        full_r  <= cmd.full_flag;
      end else if (v3_r && all_neg && !found_r) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px_r <= coord_t'(in_tdata[OFF_PX +: FIELD_W]);
      py_r <= coord_t'(in_tdata[OFF_PY +: FIELD_W]);
    end
    if (v3_r && all_neg && !found_r && !cmd.capture) begin
      region_r <= reg3_r;
    end
    if (cmd.load_out) begin
      out_region_r <= found_r ? OUT_REG_W'(region_r) : '0;
      out_hit_r    <= found_r;
      out_full_r   <= full_r;
    end
  end

  assign sts.found = found_r;
  assign sts.busy  = v1_r || v2_r || v3_r;
  assign out_tdata = {(OUT_TDATA_W - OUT_REG_W - 2)'(0), out_full_r, out_hit_r, out_region_r};

endmodule

>>> sv/pitrl_ctrl.sv
// Controller: accepts words, keeps the triangle count and sequences the table scan.
module pitrl_ctrl
  import pitrl_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic [ACTION_W-1:0] in_action,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  dp_sts_t             sts,
  output dp_cmd_t             cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.wr_idx    = count_r[IDX_W-1:0];
    cmd.rd_idx    = k_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DONE;
          case (in_action)
            ACT_APPEND: begin
              if (count_r == CNT_W'(MAX_TRIANGLES)) begin
                cmd.full_flag = 1'b1;
              end else begin
                cmd.wr_en = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            ACT_CLEAR: begin
              count_nxt = '0;
            end
            ACT_QUERY: begin
              if (count_r != '0) begin
                k_nxt     = '0;
                state_nxt = ST_SCAN;
              end
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (sts.found) begin
          state_nxt = ST_DRAIN;
        end else begin
          cmd.rd_en = 1'b1;
          if (CNT_W'(k_r) + CNT_W'(1) == count_r) begin
            state_nxt = ST_DRAIN;
          end else begin
            k_nxt = k_r + IDX_W'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (!sts.busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> sv/point_in_triangle_region_lookup_top.sv
// Top level of the point-in-triangle region lookup.
//
//   channel | direction | signals                       | contents
//   in_     | input     | in_tvalid/in_tready/in_tdata  | append, clear or query word
//           |           | in_tuser                      | action
//   out_    | output    | out_tvalid/out_tready/out_tdata | one result word per input word
//
// Append, clear and unused actions go straight to the result register once it is free.
// A query reads one triangle per cycle from the single memory read port and then
// drains a three-stage edge test pipeline; a match stops the scan early.
// Reset clears the triangle count and the control state; the memory holds no reset value.
// A new word is accepted while a finished result still waits on out_tready.
module point_in_triangle_region_lookup_top
  import pitrl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // region_tag[7:0], ax, ay, bx, by_coord, cx, cy, point_x, point_y (32 bits each)
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // action[1:0]
  input  logic [ACTION_W-1:0]    in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // region_out[7:0], hit[8], table_full[9], zero fill[15:10]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  pitrl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_action  (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  pitrl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule

>>> sv/pitrl_checker.sv
// Port-level checker for the triangle region lookup and its bind.
module pitrl_checker
  import pitrl_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word dropped or changed while stalled");

  a_full_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[9] |-> !out_tdata[8] && (out_tdata[7:0] == '0))
    else $error("table full result carries a hit or region");

  a_region_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[7:0] != '0) |-> out_tdata[8])
    else $error("nonzero region without a hit");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:10] == '0))
    else $error("result padding bits not zero");

endmodule

bind point_in_triangle_region_lookup_top pitrl_checker u_pitrl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> tb/tb_point_in_triangle_region_lookup_top.sv
// Self-checking testbench for the point-in-triangle region lookup top level.
module tb_point_in_triangle_region_lookup_top;
  import pitrl_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 900;
  localparam int DRAIN_CYCLES = MAX_TRIANGLES + 20;
  localparam longint TIMEOUT_UNITS = 64'd12_000_000;

  typedef struct packed {
    coord_t              p_y;
    coord_t              p_x;
    coord_t              c_y;
    coord_t              c_x;
    coord_t              b_y;
    coord_t              b_x;
    coord_t              a_y;
    coord_t              a_x;
    region_t             tag;
    logic [ACTION_W-1:0] action;
  } lookup_word_t;

  typedef struct packed {
    logic    full;
    logic    hit;
    region_t region;
  } lookup_result_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [ACTION_W-1:0]    in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  lookup_word_t   pending_words[$];
  lookup_result_t expected_lookups[$];
  lookup_word_t   tri_table[MAX_TRIANGLES];
  int unsigned    tri_count;

  lookup_word_t   cur_word;
  int unsigned    send_gap;
  int unsigned    send_burst;
  int unsigned    recv_gap;
  int unsigned    recv_burst;
  int unsigned    accepted_words;
  int unsigned    result_idx;
  int unsigned    total_words;
  int unsigned    mismatches;
  int unsigned    n_queries;
  int unsigned    n_hits;
  int unsigned    n_dropped;
  int unsigned    n_clears;

  point_in_triangle_region_lookup_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #(TIMEOUT_UNITS);
    $display("FAIL point_in_triangle_region_lookup_top");
    $finish;
  end

  // The point lies strictly to the left of the directed edge s->e, with exact products.
  function automatic logic edge_below(input coord_t sx, sy, ex, ey, px, py);
    diff_t dx, dy, rx, ry;
    prod_t lhs, rhs;
    dx  = diff_t'(ex) - diff_t'(sx);
    dy  = diff_t'(ey) - diff_t'(sy);
    rx  = diff_t'(px) - diff_t'(sx);
    ry  = diff_t'(py) - diff_t'(sy);
    lhs = prod_t'(rx) * prod_t'(dy);
    rhs = prod_t'(ry) * prod_t'(dx);
    return lhs < rhs;
  endfunction

  task automatic predict_lookup(input lookup_word_t w);
    lookup_result_t res;
    lookup_word_t   t;
    int unsigned    k;
    res = '0;
    case (w.action)
      ACT_APPEND: begin
        if (tri_count >= MAX_TRIANGLES) begin
          res.full = 1'b1;
          n_dropped++;
        end else begin
          tri_table[tri_count] = w;
          tri_count++;
        end
      end
      ACT_CLEAR: begin
        tri_count = 0;
        n_clears++;
      end
      ACT_QUERY: begin
        n_queries++;
        for (k = 0; k < tri_count; k++) begin
          t = tri_table[k];
          if (edge_below(t.a_x, t.a_y, t.b_x, t.b_y, w.p_x, w.p_y) &&
              edge_below(t.b_x, t.b_y, t.c_x, t.c_y, w.p_x, w.p_y) &&
              edge_below(t.c_x, t.c_y, t.a_x, t.a_y, w.p_x, w.p_y)) begin
            res.region = t.tag;
            res.hit    = 1'b1;
            n_hits++;
            break;
          end
        end
      end
      default: ;
    endcase
    expected_lookups.push_back(res);
  endtask

  task automatic report_mismatch(input string what, input int unsigned idx,
                                 input int unsigned got, input int unsigned want);
    $display("MISMATCH word %0d %s: got 0x%0h expected 0x%0h", idx, what, got, want);
    mismatches++;
  endtask

  // Mostly short gaps, some long ones, and now and then a stretch with none.
  function automatic int unsigned pick_gap(inout int unsigned burst_left);
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(20, 80);
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_lookup(cur_word);
        accepted_words++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          in_tdata <= {cur_word.p_y, cur_word.p_x, cur_word.c_y, cur_word.c_x,
                       cur_word.b_y, cur_word.b_x, cur_word.a_y, cur_word.a_x,
                       cur_word.tag};
          in_tuser <= cur_word.action;
          in_tvalid <= 1'b1;
          send_gap = pick_gap(send_burst);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_lookups.size() == 0) begin
          report_mismatch("unexpected result", result_idx, 32'(out_tdata), 0);
        end else begin
          want = expected_lookups.pop_front();
          if (out_tdata[7:0] !== want.region)
            report_mismatch("region_out", result_idx, 32'(out_tdata[7:0]),
                            32'(want.region));
          if (out_tdata[8] !== want.hit)
            report_mismatch("hit", result_idx, 32'(out_tdata[8]), 32'(want.hit));
          if (out_tdata[9] !== want.full)
            report_mismatch("table_full", result_idx, 32'(out_tdata[9]), 32'(want.full));
        end
        result_idx++;
        recv_gap = pick_gap(recv_burst);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic coord_t q16(input int v);
    return coord_t'(v * 65536);
  endfunction

  function automatic lookup_word_t tri_word(input region_t tag,
                                            input coord_t ax, ay, bx, by_v, cx, cy);
    lookup_word_t w;
    w        = '0;
    w.action = ACT_APPEND;
    w.tag    = tag;
    w.a_x    = ax;
    w.a_y    = ay;
    w.b_x    = bx;
    w.b_y    = by_v;
    w.c_x    = cx;
    w.c_y    = cy;
    return w;
  endfunction

  function automatic lookup_word_t point_word(input coord_t px, py);
    lookup_word_t w;
    w        = '0;
    w.action = ACT_QUERY;
    w.p_x    = px;
    w.p_y    = py;
    return w;
  endfunction

  function automatic lookup_word_t random_word(input logic [ACTION_W-1:0] act);
    lookup_word_t w;
    w.action = act;
    w.tag    = region_t'($urandom_range(0, 255));
    w.a_x    = coord_t'($urandom);
    w.a_y    = coord_t'($urandom);
    w.b_x    = coord_t'($urandom);
    w.b_y    = coord_t'($urandom);
    w.c_x    = coord_t'($urandom);
    w.c_y    = coord_t'($urandom);
    w.p_x    = coord_t'($urandom);
    w.p_y    = coord_t'($urandom);
    return w;
  endfunction

  function automatic coord_t pick_coord();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 3))
        0:       return coord_t'(32'h8000_0000);
        1:       return coord_t'(32'h7FFF_FFFF);
        2:       return coord_t'(0);
        default: return coord_t'(-1);
      endcase
    end
    if (r < 30) return coord_t'($urandom);
    return coord_t'(int'($urandom_range(0, 2097152)) - 1048576);
  endfunction

  initial begin
    lookup_word_t w;
    lookup_word_t t;
    lookup_word_t shadow[$];
    coord_t       tmp;
    int unsigned  random_words;
    int unsigned  phase;
    int unsigned  n_app;
    int unsigned  n_q;
    int unsigned  r;
    logic         do_fill;
    logic         late_fill;
    coord_t       cmin;
    coord_t       cmax;

    cmin = coord_t'(32'h8000_0000);
    cmax = coord_t'(32'h7FFF_FFFF);

    pending_words.push_back(point_word(q16(0), q16(0)));
    pending_words.push_back(tri_word(8'd5, q16(0), q16(0), q16(10), q16(0), q16(0), q16(10)));
    pending_words.push_back(point_word(q16(2), q16(2)));
    pending_words.push_back(point_word(q16(5), q16(0)));
    pending_words.push_back(point_word(q16(0), q16(0)));
    pending_words.push_back(point_word(q16(5), q16(5)));
    // A clockwise triangle never matches.
    pending_words.push_back(tri_word(8'd7, q16(20), q16(0), q16(20), q16(10), q16(30), q16(0)));
    pending_words.push_back(point_word(q16(22), q16(2)));
    // A degenerate triangle never matches, even on its own line.
    pending_words.push_back(tri_word(8'd9, q16(40), q16(0), q16(45), q16(5), q16(50), q16(10)));
    pending_words.push_back(point_word(q16(45), q16(5)));
    // A match on a triangle tagged with region zero still reports a hit.
    pending_words.push_back(tri_word(8'd0, q16(0), q16(20), q16(10), q16(20), q16(0), q16(30)));
    pending_words.push_back(point_word(q16(1), q16(21)));
    // An overlapping later triangle loses to the earlier one.
    pending_words.push_back(tri_word(8'd3, q16(-10), q16(-10), q16(20), q16(-10),
                                     q16(-10), q16(20)));
    pending_words.push_back(point_word(q16(1), q16(1)));
    pending_words.push_back(point_word(q16(-5), q16(-5)));
    pending_words.push_back(tri_word(8'd255, cmin, cmin, cmax, cmin, cmin, cmax));
    pending_words.push_back(point_word(coord_t'(32'h8000_0010), coord_t'(32'h8000_0010)));
    pending_words.push_back(point_word(cmax, cmax));
    pending_words.push_back(point_word(cmin, cmax));
    pending_words.push_back(point_word(q16(0), q16(0)));
    pending_words.push_back(random_word(ACT_UNUSED));
    pending_words.push_back(random_word(ACT_CLEAR));
    pending_words.push_back(point_word(q16(2), q16(2)));

    random_words = 0;
    phase        = 0;
    late_fill    = 1'b0;
    while (random_words < RANDOM_WORDS) begin
      phase++;
      if ($urandom_range(0, 3) == 0) begin
        pending_words.push_back(random_word(ACT_CLEAR));
        random_words++;
        shadow.delete();
      end
      do_fill = (phase == 3) || (!late_fill && random_words > 500);
      if (do_fill && phase != 3) late_fill = 1'b1;
      n_app = do_fill ? MAX_TRIANGLES + $urandom_range(1, 3) : $urandom_range(1, 10);
      repeat (n_app) begin
        w     = random_word(ACT_APPEND);
        w.a_x = pick_coord();
        w.a_y = pick_coord();
        w.b_x = pick_coord();
        w.b_y = pick_coord();
        w.c_x = pick_coord();
        w.c_y = pick_coord();
        if ($urandom_range(0, 4) != 0 &&
            !edge_below(w.a_x, w.a_y, w.b_x, w.b_y, w.c_x, w.c_y)) begin
          tmp = w.b_x; w.b_x = w.c_x; w.c_x = tmp;
          tmp = w.b_y; w.b_y = w.c_y; w.c_y = tmp;
        end
        pending_words.push_back(w);
        random_words++;
        if (shadow.size() < MAX_TRIANGLES) shadow.push_back(w);
      end
      n_q = do_fill ? 30 : $urandom_range(3, 12);
      repeat (n_q) begin
        w = random_word(ACT_QUERY);
        r = $urandom_range(0, 99);
        if (shadow.size() > 0 && r < 75) t = shadow[$urandom_range(0, shadow.size() - 1)];
        if (shadow.size() > 0 && r < 60) begin
          w.p_x = coord_t'((longint'(t.a_x) + t.b_x + t.c_x) / 3);
          w.p_y = coord_t'((longint'(t.a_y) + t.b_y + t.c_y) / 3);
        end else if (shadow.size() > 0 && r < 75) begin
          if (r < 68) begin
            w.p_x = coord_t'((longint'(t.a_x) + t.b_x) / 2);
            w.p_y = coord_t'((longint'(t.a_y) + t.b_y) / 2);
          end else begin
            w.p_x = t.c_x;
            w.p_y = t.c_y;
          end
        end else if (r < 80) begin
          w.action = ACT_UNUSED;
        end else if (r < 90) begin
          w.p_x = pick_coord();
          w.p_y = pick_coord();
        end
        pending_words.push_back(w);
        if (w.action != ACT_UNUSED) random_words++;
      end
    end
    total_words = pending_words.size();

    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (accepted_words < total_words || expected_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (expected_lookups.size() != 0) begin
      report_mismatch("missing result", result_idx, 0, 32'(expected_lookups.pop_front()));
      result_idx++;
    end

    $display("Run covered %0d words: %0d queries with %0d hits, %0d clears, %0d dropped appends.",
             accepted_words, n_queries, n_hits, n_clears, n_dropped);
    $display("Results checked: %0d, mismatches: %0d.", result_idx, mismatches);
    if (mismatches == 0) begin
      $display("PASS point_in_triangle_region_lookup_top");
    end else begin
      $display("FAIL point_in_triangle_region_lookup_top");
    end
    $finish;
  end

endmodule
